// ===== design/mbt_pkg.sv =====
package mbt_pkg;

  // Default configuration of the block.
  localparam int unsigned FRAC_BITS_DEF   = 28;
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned ITER_BITS_DEF   = 16;

  // Value of max_iters after reset.
  localparam int unsigned MAX_ITERS_RESET = 256;

  // Sequencer states. One iteration walks CHECK, SQ_IMAG, CROSS, UPDATE.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SQ_IMAG,
    S_CROSS,
    S_UPDATE,
    S_DONE
  } mbt_state_e;

  // Finished test handed from the sequencer to the output register.
  typedef struct packed {
    logic done;
    logic in_set;
  } mbt_res_t;

endpackage

// ===== design/mbt_pt_if.sv =====
interface mbt_pt_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] c_real;
  logic signed [COORD_WIDTH-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// ===== design/mbt_res_if.sv =====
interface mbt_res_if;
  logic valid;
  logic ready;
  logic in_set;

  modport source (output valid, output in_set, input ready);
  modport sink   (input valid, input in_set, output ready);
endinterface

// ===== design/mbt_mul.sv =====
module mbt_mul #(
  parameter int unsigned W = 30
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  // Product is registered; it is read in the cycle after the operands are set.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== design/mbt_core.sv =====
module mbt_core #(
  parameter int unsigned FRAC_BITS   = mbt_pkg::FRAC_BITS_DEF,
  parameter int unsigned COORD_WIDTH = mbt_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ITER_BITS   = mbt_pkg::ITER_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]       c_real_i,
  input  logic signed [COORD_WIDTH-1:0]       c_imag_i,
  input  logic        [ITER_BITS-1:0]         max_iters_i,
  input  logic                                out_free_i,
  output mbt_pkg::mbt_res_t                   res_o,
  output logic signed [FRAC_BITS+1:0]         mul_a_o,
  output logic signed [FRAC_BITS+1:0]         mul_b_o,
  input  logic signed [2*(FRAC_BITS+2)-1:0]   mul_p_i
);

  import mbt_pkg::*;

  localparam int unsigned OP_W   = FRAC_BITS + 2;
  localparam int unsigned PROD_W = 2 * OP_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned ZI_W   =
    ((COORD_WIDTH > FRAC_BITS + 4) ? COORD_WIDTH : FRAC_BITS + 4) + 2;
  localparam int unsigned EXT_W  = ((SUM_W > ZI_W) ? SUM_W : ZI_W) + 1;

  localparam logic signed [ZI_W-1:0] TWO =
    {{(ZI_W-FRAC_BITS-2){1'b0}}, 1'b1, {(FRAC_BITS+1){1'b0}}};
  localparam logic signed [ZI_W-1:0] NEG_TWO = -TWO;
  localparam logic signed [SUM_W-1:0] FOUR =
    {3'b001, {(2*FRAC_BITS+2){1'b0}}};

  mbt_state_e state_q, state_d;

  logic signed [COORD_WIDTH-1:0] cr_q, ci_q;
  logic signed [ZI_W-1:0]        zr_q, zi_q;
  logic signed [PROD_W-1:0]      rr_q, ii_q;
  logic        [ITER_BITS-1:0]   iter_q;
  logic                          in_set_q;

  logic                          accept;
  logic                          coord_big;
  logic                          mag_escaped;
  logic                          at_limit;
  logic signed [SUM_W-1:0]       mag;
  logic signed [SUM_W-1:0]       diff;
  logic signed [SUM_W-1:0]       diff_shr;
  logic signed [PROD_W-1:0]      cross_shr;
  logic signed [EXT_W-1:0]       nr_ext, ni_ext;

  assign accept = in_valid_i && in_ready_o;

  // A part of 2 or more in magnitude has escaped without any square.
  assign coord_big = (zr_q >= TWO) || (zr_q <= NEG_TWO) ||
                     (zi_q >= TWO) || (zi_q <= NEG_TWO);

  assign mag         = SUM_W'(rr_q) + SUM_W'(ii_q);
  assign mag_escaped = (mag >= FOUR);
  assign at_limit    = (iter_q == max_iters_i);

  // Floor shifts back to the coordinate scale; the doubled cross term
  // shifts by one place less.
  assign diff      = SUM_W'(rr_q) - SUM_W'(ii_q);
  assign diff_shr  = diff >>> FRAC_BITS;
  assign cross_shr = mul_p_i >>> (FRAC_BITS - 1);
  assign nr_ext    = EXT_W'(diff_shr) + EXT_W'(cr_q);
  assign ni_ext    = EXT_W'(cross_shr) + EXT_W'(ci_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_CHECK;
      S_CHECK:   state_d = coord_big ? S_DONE : S_SQ_IMAG;
      S_SQ_IMAG: state_d = S_CROSS;
      S_CROSS:   state_d = S_UPDATE;
      S_UPDATE:  state_d = (mag_escaped || at_limit) ? S_DONE : S_CHECK;
      S_DONE:    if (out_free_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    res_o.done    = 1'b0;
    res_o.in_set  = in_set_q;
    mul_a_o       = zr_q[OP_W-1:0];
    mul_b_o       = zr_q[OP_W-1:0];
    case (state_q)
      S_IDLE:    in_ready_o = 1'b1;
      S_CHECK: begin
        mul_a_o = zr_q[OP_W-1:0];
        mul_b_o = zr_q[OP_W-1:0];
      end
      S_SQ_IMAG: begin
        mul_a_o = zi_q[OP_W-1:0];
        mul_b_o = zi_q[OP_W-1:0];
      end
      S_CROSS: begin
        mul_a_o = zr_q[OP_W-1:0];
        mul_b_o = zi_q[OP_W-1:0];
      end
      S_DONE:    res_o.done = 1'b1;
      default:   in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      iter_q   <= '0;
      in_set_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (accept) iter_q <= '0;
        end
        S_CHECK: begin
          if (coord_big) in_set_q <= 1'b0;
        end
        S_UPDATE: begin
          if (mag_escaped) begin
            in_set_q <= 1'b0;
          end else if (at_limit) begin
            in_set_q <= 1'b1;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        default: iter_q <= iter_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cr_q <= c_real_i;
          ci_q <= c_imag_i;
          zr_q <= '0;
          zi_q <= '0;
        end
      end
      S_SQ_IMAG: rr_q <= mul_p_i;
      S_CROSS:   ii_q <= mul_p_i;
      S_UPDATE: begin
        if (!mag_escaped && !at_limit) begin
          zr_q <= ZI_W'(nr_ext);
          zi_q <= ZI_W'(ni_ext);
        end
      end
      default: rr_q <= rr_q;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CHECK))
    else $error("accepted point did not start an iteration");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (iter_q <= max_iters_i))
    else $error("iteration count ran past the limit");

  a_in_set_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.done && res_o.in_set) |-> at_limit)
    else $error("point reported in the set before the limit");

  a_sq_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ_IMAG) |-> ($past(state_q) == S_CHECK))
    else $error("imaginary square not preceded by the range check");

endmodule

// ===== design/mandelbrot_membership_test.sv =====
// Channel   Modport  Direction  Payload
// point_i   sink     in         c_real, c_imag (signed Q3.28)
// result_o  source   out        in_set
// max_iters write enable and data, no handshake
//
// Each iteration walks the CHECK, SQ_IMAG, CROSS and UPDATE states. The pass
// that finds the limit or an escape through |z|^2 ends in the UPDATE state,
// and an iterate that is 2 or more on one axis ends its pass in the CHECK
// state. Each point enters from the idle state and leaves through the done state.
// One shared multiplier forms the real square, the imaginary square and the
// cross product in turn.
// A point that stays in the set runs max_iters iterations. Reset is
// asynchronous and active low; it empties the sequencer and the output
// register and sets max_iters to 256.
// The finished result sits in an output register, so a new point is taken
// while it waits; a result that cannot leave holds the sequencer in its final
// state until the register frees.
module mandelbrot_membership_test #(
  parameter int unsigned FRAC_BITS   = mbt_pkg::FRAC_BITS_DEF,
  parameter int unsigned COORD_WIDTH = mbt_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ITER_BITS   = mbt_pkg::ITER_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mbt_pt_if.sink               point_i,
  mbt_res_if.source            result_o,
  input  logic                 max_iters_we_i,
  input  logic [ITER_BITS-1:0] max_iters_i
);

  import mbt_pkg::*;

  localparam int unsigned OP_W = FRAC_BITS + 2;

  // Iteration limit register; the user writes it only while the block is idle, which the block does not check.
  logic [ITER_BITS-1:0] max_iters_q;

  // Output register. It is free when empty or when its item leaves now.
  logic res_valid_q;
  logic res_in_set_q;
  logic out_free;

  mbt_res_t                 res;
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [2*OP_W-1:0] mul_p;

  assign out_free = !res_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iters_q <= ITER_BITS'(MAX_ITERS_RESET);
    end else if (max_iters_we_i) begin
      max_iters_q <= max_iters_i;
    end
  end

  // The sequencer owns the iterate and the escape decisions.
  mbt_core #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH),
    .ITER_BITS   (ITER_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (point_i.ready),
    .c_real_i    (point_i.c_real),
    .c_imag_i    (point_i.c_imag),
    .max_iters_i (max_iters_q),
    .out_free_i  (out_free),
    .res_o       (res),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_p_i     (mul_p)
  );

  // The one multiplier of the block, reused three times per iteration.
  mbt_mul #(
    .W (OP_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // The result enters the register in the same cycle that the sequencer
  // leaves its final state, so each point yields exactly one item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= res.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.done) begin
      res_in_set_q <= res.in_set;
    end
  end

  assign result_o.valid  = res_valid_q;
  assign result_o.in_set = res_in_set_q;

endmodule

// ===== bench/tb.sv =====
module tb;

  // Block configuration, taken from the package so the bench follows the RTL defaults.
  localparam int unsigned FRAC = mbt_pkg::FRAC_BITS_DEF;
  localparam int unsigned CW   = mbt_pkg::COORD_WIDTH_DEF;
  localparam int unsigned IW   = mbt_pkg::ITER_BITS_DEF;

  // Escape thresholds. A single coordinate at or beyond 2.0 escapes at once; otherwise
  // |z|^2 is compared exactly against 4.0 in the double-width product format.
  localparam longint ESC_COORD = 64'sd1 <<< (FRAC + 1);
  localparam longint ESC_NORM  = 64'sd1 <<< (2 * FRAC + 2);

  // Handy Q3.28 constants for the directed points.
  localparam logic signed [CW-1:0] Q_ZERO    = 32'sh0000_0000;
  localparam logic signed [CW-1:0] Q_QUARTER = 32'sh0400_0000;
  localparam logic signed [CW-1:0] Q_ONE     = 32'sh1000_0000;
  localparam logic signed [CW-1:0] Q_TWO     = 32'sh2000_0000;
  localparam logic signed [CW-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] Q_MIN     = 32'sh8000_0000;

  localparam int          IDLE_PCT    = 27;
  localparam int          HOLD_CYCLES = 2000;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // How a directed row gets its expected answer: typed in, or from the predictor.
  typedef enum logic [1:0] {
    ROW_OUT,
    ROW_IN,
    ROW_PREDICT
  } row_check_e;

  typedef struct packed {
    logic signed [CW-1:0] re;
    logic signed [CW-1:0] im;
  } point_t;

  typedef struct packed {
    point_t     c;
    row_check_e check;
  } dir_row_t;

  // Directed table, run at the reset value of max_iters (256). Rows with a typed
  // answer are the obvious ones: the origin, the period-two point at -1, any point
  // that lands on or beyond 2.0 on an axis in the first step (exactly 2.0 counts as
  // escaped), and the corners of the coordinate range. Points just inside the
  // radius, around the cusp at 0.25, at i, and near the boundary go to the predictor.
  localparam int DIR_ROWS = 22;
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{Q_ZERO,          Q_ZERO},          ROW_IN},
    '{'{-Q_ONE,          Q_ZERO},          ROW_IN},
    '{'{-Q_TWO,          Q_ZERO},          ROW_OUT},
    '{'{Q_TWO,           Q_ZERO},          ROW_OUT},
    '{'{Q_ZERO,          Q_TWO},           ROW_OUT},
    '{'{Q_ZERO,          -Q_TWO},          ROW_OUT},
    '{'{Q_TWO - 1,       Q_ZERO},          ROW_PREDICT},
    '{'{Q_ZERO,          Q_TWO - 1},       ROW_PREDICT},
    '{'{1 - Q_TWO,       Q_ZERO},          ROW_PREDICT},
    '{'{Q_MIN,           Q_MIN},           ROW_OUT},
    '{'{Q_MAX,           Q_MAX},           ROW_OUT},
    '{'{Q_MIN,           Q_MAX},           ROW_OUT},
    '{'{Q_MAX,           Q_MIN},           ROW_OUT},
    '{'{Q_MIN,           Q_ZERO},          ROW_OUT},
    '{'{Q_ZERO,          Q_MAX},           ROW_OUT},
    '{'{Q_QUARTER,       Q_ZERO},          ROW_PREDICT},
    '{'{Q_QUARTER + 1,   Q_ZERO},          ROW_PREDICT},
    '{'{Q_ZERO,          Q_ONE},           ROW_PREDICT},
    '{'{32'sd1,          Q_ZERO},          ROW_PREDICT},
    '{'{-32'sd1,         -32'sd1},         ROW_PREDICT},
    '{'{-32'sh0C00_0000, 32'sh0199_999A},  ROW_PREDICT},
    '{'{32'sh0600_0000,  32'sh0A00_0000},  ROW_PREDICT}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic          max_iters_we;
  logic [IW-1:0] max_iters_val;

  mbt_pt_if #(.COORD_WIDTH(CW)) pt_ch ();
  mbt_res_if                    res_ch ();

  mandelbrot_membership_test dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .point_i        (pt_ch),
    .result_o       (res_ch),
    .max_iters_we_i (max_iters_we),
    .max_iters_i    (max_iters_val)
  );

  always #5 clk_i = ~clk_i;

  // Expected in_set answers, oldest first, one per accepted point.
  bit          in_set_q [$];
  bit          expected_in_set;
  int unsigned cur_max_iters = mbt_pkg::MAX_ITERS_RESET;
  int unsigned points_sent;
  int unsigned results_checked;
  int unsigned in_set_hits;
  int unsigned settings_used;
  int unsigned fail_count;
  int unsigned cycle_cnt;

  // Idling switch shared by both channels, and the request for a long result hold.
  bit idle_on = 1'b1;
  bit hold_req;
  int hold_left;

  // True when the iterate has escaped: either coordinate at or past 2.0, or |z|^2 >= 4.
  function automatic bit norm_reaches_four(input longint zr, input longint zi);
    if ((zr < 0 ? -zr : zr) >= ESC_COORD || (zi < 0 ? -zi : zi) >= ESC_COORD) begin
      return 1'b1;
    end
    return zr * zr + zi * zi >= ESC_NORM;
  endfunction

  // Runs z = z*z + c from the origin for at most iter_limit steps. Products are exact
  // in 64 bits and brought back to Q.28 with an arithmetic shift, i.e. rounded down.
  function automatic bit point_stays_bounded(input logic signed [CW-1:0] c_re,
                                              input logic signed [CW-1:0] c_im,
                                              input int unsigned iter_limit);
    longint      cr;
    longint      ci;
    longint      zr;
    longint      zi;
    longint      nr;
    int unsigned n;
    bit          gone;
    cr = c_re;
    ci = c_im;
    zr = 0;
    zi = 0;
    n = 0;
    gone = norm_reaches_four(zr, zi);
    while (n < iter_limit && !gone) begin
      nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
      zi = ((2 * zr * zi) >>> FRAC) + ci;
      zr = nr;
      n++;
      gone = norm_reaches_four(zr, zi);
    end
    return !gone;
  endfunction

  // Coordinates right at the escape radius and at the ends of the range, plus zero and -1.0.
  function automatic logic signed [CW-1:0] rim_coord();
    case ($urandom_range(0, 7))
      0:       return Q_ZERO;
      1:       return Q_TWO;
      2:       return -Q_TWO;
      3:       return Q_TWO - 1;
      4:       return 1 - Q_TWO;
      5:       return Q_MIN;
      6:       return Q_MAX;
      default: return -Q_ONE;
    endcase
  endfunction

  // Random point. Most land in the window around the set or close to spots on its
  // boundary, where escape times spread widely; the rest are raw 32-bit values
  // (mostly instant escapes) and points sitting on the escape radius.
  function automatic point_t pick_point();
    point_t      p;
    int unsigned sel;
    int unsigned span;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      // Real part in [-2.0, 0.5], imaginary part in [-1.25, 1.25].
      p.re = $urandom_range(0, 32'd671088640) - 32'd536870912;
      p.im = $urandom_range(0, 32'd671088640) - 32'd335544320;
    end else if (sel < 70) begin
      span = 1 << $urandom_range(4, 22);
      case ($urandom_range(0, 5))
        0:       p = '{Q_QUARTER, Q_ZERO};
        1:       p = '{-32'sh0C00_0000, Q_ZERO};
        2:       p = '{-32'sh1400_0000, Q_ZERO};
        3:       p = '{-Q_TWO, Q_ZERO};
        4:       p = '{Q_ZERO, Q_ONE};
        default: p = '{-32'sh0199_999A, 32'sh0A66_6666};
      endcase
      p.re = p.re + ($urandom_range(0, 2 * span) - span);
      p.im = p.im + ($urandom_range(0, 2 * span) - span);
    end else if (sel < 88) begin
      p.re = $urandom();
      p.im = $urandom();
    end else begin
      p.re = rim_coord();
      p.im = rim_coord();
    end
    return p;
  endfunction

  // Offers one point, with random idle cycles ahead of it, and records the expected
  // answer at the edge where the block takes it. Valid stays high from one point to
  // the next when no idle cycle falls between them.
  task automatic offer_point(input point_t p, input bit stays);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      pt_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pt_ch.valid  <= 1'b1;
    pt_ch.c_real <= p.re;
    pt_ch.c_imag <= p.im;
    @(posedge clk_i);
    while (!pt_ch.ready) @(posedge clk_i);
    in_set_q.push_back(stays);
    points_sent++;
  endtask

  // Stops offering and waits for every outstanding answer. Always waits on the clock
  // before it checks the queue, so valid is never lowered and raised again in the same step.
  task automatic drain_results();
    pt_ch.valid <= 1'b0;
    do @(posedge clk_i); while (in_set_q.size() != 0);
  endtask

  // The register is only written with the block empty.
  task automatic set_max_iters(input logic [IW-1:0] iters);
    drain_results();
    max_iters_we  <= 1'b1;
    max_iters_val <= iters;
    @(posedge clk_i);
    max_iters_we  <= 1'b0;
    cur_max_iters = iters;
    settings_used++;
  endtask

  // One setting of max_iters followed by random points. pause_at makes the sender
  // wait for all answers part way through; hold_results asks the result side for a
  // long hold so the output register and the sequencer both fill up.
  task automatic run_random_phase(input logic [IW-1:0] iters, input int n_points,
                                  input int pause_at, input bit hold_results);
    point_t p;
    set_max_iters(iters);
    if (hold_results) begin
      hold_req = 1'b1;
    end
    for (int k = 0; k < n_points; k++) begin
      if (k == pause_at) begin
        drain_results();
      end
      p = pick_point();
      offer_point(p, point_stays_bounded(p.re, p.im, cur_max_iters));
    end
  endtask

  // Result side: random stalls, plus the long hold when one is asked for. The hold
  // is counted here so the sender keeps offering points while it lasts.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Every result leaving the block is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (in_set_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual in_set %0b",
                 $time, res_ch.in_set);
        fail_count++;
      end else begin
        expected_in_set = in_set_q.pop_front();
        if (res_ch.in_set !== expected_in_set) begin
          $display("%0t: in_set mismatch, expected %0b, actual %0b",
                   $time, expected_in_set, res_ch.in_set);
          fail_count++;
        end
        in_set_hits += expected_in_set;
      end
      results_checked++;
    end
  end

  // Watchdog. The budget covers the slowest legal run many times over, including
  // the one point that never escapes at the largest max_iters.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d answers still due",
               $time, cycle_cnt, in_set_q.size());
      $display("mandelbrot_membership_test verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    point_t p;
    bit     stays;
    rst_ni        = 1'b0;
    pt_ch.valid   = 1'b0;
    pt_ch.c_real  = '0;
    pt_ch.c_imag  = '0;
    res_ch.ready  = 1'b0;
    max_iters_we  = 1'b0;
    max_iters_val = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset value of max_iters.
    for (int r = 0; r < DIR_ROWS; r++) begin
      case (dir_rows[r].check)
        ROW_IN:  stays = 1'b1;
        ROW_OUT: stays = 1'b0;
        default: stays = point_stays_bounded(dir_rows[r].c.re, dir_rows[r].c.im,
                                             cur_max_iters);
      endcase
      offer_point(dir_rows[r].c, stays);
    end

    // Smallest settings: with zero iterations every point is in the set, and with
    // one only points that leave the radius at once are out. The third phase also has
    // the sender wait for every answer half way through.
    run_random_phase(IW'(0), 60, -1, 1'b0);
    run_random_phase(IW'(1), 80, -1, 1'b0);
    run_random_phase(IW'(2), 80, 40, 1'b0);

    // Largest setting: the origin runs the full 65535 iterations, which checks the
    // iteration counter at its top value; the other points escape in one step.
    set_max_iters('1);
    p = '{Q_ZERO, Q_ZERO};
    offer_point(p, point_stays_bounded(p.re, p.im, cur_max_iters));
    for (int k = 0; k < 3; k++) begin
      p.re = Q_TWO + $urandom_range(0, 32'h5FFF_FFFF);
      p.im = $urandom();
      offer_point(p, point_stays_bounded(p.re, p.im, cur_max_iters));
    end

    // Bulk of the run: short random iteration limits keep the points cheap while
    // escape times still vary. One phase runs with no idling on either side.
    for (int ph = 0; ph < 7; ph++) begin
      idle_on = (ph != 4);
      run_random_phase(IW'($urandom_range(3, 48)), 210, -1, 1'b0);
    end
    idle_on = 1'b1;

    // Back to the reset value, written explicitly this time.
    run_random_phase(IW'(mbt_pkg::MAX_ITERS_RESET), 100, -1, 1'b0);

    // Short points with the result side held off: the block fills and must stall
    // its input until the hold ends.
    run_random_phase(IW'(4), 60, -1, 1'b1);

    drain_results();
    repeat (50) @(posedge clk_i);

    $display("Run covered %0d points (%0d in the set) over %0d writes of max_iters,",
             points_sent, in_set_hits, settings_used);
    $display("from 0 to 65535, with %0d results checked under random and long stalls.",
             results_checked);
    if (fail_count == 0) begin
      $display("mandelbrot_membership_test verification clean");
    end else begin
      $display("mandelbrot_membership_test verification failed");
    end
    $finish;
  end

endmodule
